/* rtl/sbsd_pkg.sv */
package sbsd_pkg;

	typedef enum logic [3:0] {
		KIND_INSTR     = 4'd0,
		KIND_UNKNOWN   = 4'd1,
		KIND_SW_HEAD   = 4'd2,
		KIND_SW_TARGET = 4'd3,
		KIND_NAME_CHAR = 4'd4,
		KIND_NAME_END  = 4'd5,
		KIND_END       = 4'd6,
		KIND_STOP      = 4'd7,
		KIND_TRUNC     = 4'd8
	} rec_kind_t;

	typedef enum logic [2:0] {
		PH_OPCODE,
		PH_IMM,
		PH_SWCOUNT,
		PH_SWENTRY,
		PH_NAME
	} phase_t;

	localparam logic [7:0] OP_NOP        = 8'h00;
	localparam logic [7:0] OP_PUSH_DWORD = 8'h01;
	localparam logic [7:0] OP_PUSH_WORD  = 8'h02;
	localparam logic [7:0] OP_PUSH_BYTE  = 8'h03;
	localparam logic [7:0] OP_SINGLE_04  = 8'h04;
	localparam logic [7:0] OP_LOAD_VAR   = 8'h05;
	localparam logic [7:0] OP_STORE_VAR  = 8'h06;
	localparam logic [7:0] OP_PUSH_ADDR  = 8'h07;
	localparam logic [7:0] OP_SINGLE_LO  = 8'h08;
	localparam logic [7:0] OP_SINGLE_HI  = 8'h1F;
	localparam logic [7:0] OP_JUMP_20    = 8'h20;
	localparam logic [7:0] OP_JUMP_21    = 8'h21;
	localparam logic [7:0] OP_SINGLE_22  = 8'h22;
	localparam logic [7:0] OP_JUMP_23    = 8'h23;
	localparam logic [7:0] OP_SWITCH     = 8'h24;
	localparam logic [7:0] OP_END        = 8'h25;
	localparam logic [7:0] OP_PUSH_RAW   = 8'h26;
	localparam logic [7:0] OP_CALL_NAME  = 8'h27;
	localparam logic [7:0] OP_FRAME      = 8'h28;

	localparam logic [31:0] ANY_VALUE = 32'h7FFF_FFFF;
	localparam logic [7:0]  VAR_LIMIT = 8'd4;

	localparam int SLOTS       = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// slot 0: outcome of a held zero, slot 1: main record, slot 2: truncation
	localparam int SLOT_ZERO  = 0;
	localparam int SLOT_MAIN  = 1;
	localparam int SLOT_TRUNC = 2;

	typedef struct packed {
		logic [15:0] instr_offset;
		logic [7:0]  opcode;
		rec_kind_t   kind;
		logic [31:0] value_a;
		logic [15:0] value_b;
		logic        any_marker;
		logic        bad_variable;
	} rec_t;

	typedef struct packed {
		logic [SLOTS-1:0] vmask;
		rec_t [SLOTS-1:0] rec;
	} bundle_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] sx8(input logic [7:0] v);
		return {{24{v[7]}}, v};
	endfunction

	function automatic logic [2:0] operand_len(input logic [7:0] op);
		logic [2:0] len;
		case (op)
			OP_PUSH_DWORD, OP_PUSH_RAW, OP_FRAME:             len = 3'd4;
			OP_PUSH_WORD, OP_JUMP_20, OP_JUMP_21, OP_JUMP_23: len = 3'd2;
			OP_PUSH_BYTE, OP_LOAD_VAR, OP_STORE_VAR:          len = 3'd1;
			default:                                          len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic is_single(input logic [7:0] op);
		return (op == OP_SINGLE_04) || (op == OP_SINGLE_22) ||
			((op >= OP_SINGLE_LO) && (op <= OP_SINGLE_HI));
	endfunction

	function automatic rec_t make_rec(input logic [15:0] off, input logic [7:0] op,
			input rec_kind_t kind, input logic [31:0] a);
		rec_t r;
		r.instr_offset = off;
		r.opcode       = op;
		r.kind         = kind;
		r.value_a      = a;
		r.value_b      = '0;
		r.any_marker   = 1'b0;
		r.bad_variable = 1'b0;
		return r;
	endfunction

	function automatic rec_t finish_imm(input logic [15:0] off, input logic [7:0] op,
			input logic [31:0] v, input logic [15:0] ffw);
		rec_t r;
		r = make_rec(off, op, KIND_INSTR, '0);
		case (op)
			OP_PUSH_DWORD: begin
				r.value_a    = v;
				r.any_marker = (v == ANY_VALUE);
			end
			OP_PUSH_RAW: r.value_a = v;
			OP_FRAME: begin
				r.value_a = sx16(ffw);
				r.value_b = v[31:16];
			end
			OP_PUSH_BYTE: r.value_a = sx8(v[7:0]);
			OP_LOAD_VAR, OP_STORE_VAR: begin
				r.value_a      = {24'd0, v[7:0]};
				r.bad_variable = (v[7:0] >= VAR_LIMIT);
			end
			default: r.value_a = sx16(v[15:0]);
		endcase
		return r;
	endfunction

endpackage

/* rtl/sbsd_in_if.sv */
interface sbsd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] code_byte;
	logic       stream_last;

	modport source(output valid, output code_byte, output stream_last, input ready);
	modport sink(input valid, input code_byte, input stream_last, output ready);
endinterface

/* rtl/sbsd_out_if.sv */
interface sbsd_out_if;
	logic               valid;
	logic               ready;
	logic [15:0]        instr_offset;
	logic [7:0]         opcode;
	logic [3:0]         record_kind;
	logic signed [31:0] value_a;
	logic signed [15:0] value_b;
	logic               any_marker;
	logic               bad_variable;
	logic               run_last;

	modport source(output valid, output instr_offset, output opcode, output record_kind,
		output value_a, output value_b, output any_marker, output bad_variable,
		output run_last, input ready);
	modport sink(input valid, input instr_offset, input opcode, input record_kind,
		input value_a, input value_b, input any_marker, input bad_variable,
		input run_last, output ready);
endinterface

/* rtl/sbsd_front.sv */
module sbsd_front #(
	parameter int OFFSET_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	sbsd_in_if.sink          code,
	input  logic             full,
	output logic             push,
	output sbsd_pkg::bundle_t bundle
);
	import sbsd_pkg::*;

	logic [OFFSET_BITS-1:0] off_q, off_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	phase_t                 phase_q, phase_n;
	logic [7:0]             held_q, held_n;
	logic [31:0]            acc_q, acc_n;
	logic [2:0]             left_q, left_n;
	logic [7:0]             swleft_q, swleft_n;
	logic [15:0]            ffw_q, ffw_n;
	logic                   pzero_q, pzero_n;
	logic                   halted_q, halted_n;

	logic        accept;
	logic        take;
	logic [7:0]  b;
	logic        last;
	logic [2:0]  len_rem;
	logic [1:0]  pos;
	logic [31:0] off_w;
	logic [31:0] start_w;
	logic [31:0] trunc_w;
	bundle_t     bundle_n;

	assign code.ready = !full;
	assign accept     = code.valid && code.ready;
	assign b          = code.code_byte;
	assign last       = code.stream_last;
	assign off_w      = 32'(off_q);
	assign start_w    = 32'(start_q);

	always_comb begin
		phase_n  = phase_q;
		held_n   = held_q;
		start_n  = start_q;
		acc_n    = acc_q;
		left_n   = left_q;
		swleft_n = swleft_q;
		ffw_n    = ffw_q;
		pzero_n  = pzero_q;
		halted_n = halted_q;
		off_n    = off_q;
		take     = 1'b0;
		len_rem  = '0;
		pos      = '0;
		trunc_w  = '0;
		bundle_n = '0;

		if (accept && !halted_q) begin
			case (phase_q)
				PH_IMM: begin
					len_rem = operand_len(held_q) - left_q;
					pos     = len_rem[1:0];
					acc_n   = acc_q | (32'(b) << {pos, 3'b000});
					left_n  = left_q - 3'd1;
					if ((held_q == OP_FRAME) && (left_n == 3'd2))
						ffw_n = acc_n[15:0];
					if (left_n == 3'd0) begin
						phase_n = PH_OPCODE;
						bundle_n.vmask[SLOT_MAIN] = 1'b1;
						bundle_n.rec[SLOT_MAIN]   = finish_imm(start_w[15:0], held_q, acc_n, ffw_n);
					end
				end
				PH_SWCOUNT: begin
					swleft_n = b;
					bundle_n.vmask[SLOT_MAIN] = 1'b1;
					bundle_n.rec[SLOT_MAIN]   = make_rec(start_w[15:0], held_q, KIND_SW_HEAD,
						32'(b));
					if (b == 8'd0) begin
						phase_n = PH_OPCODE;
					end else begin
						phase_n = PH_SWENTRY;
						left_n  = 3'd2;
						acc_n   = '0;
					end
				end
				PH_SWENTRY: begin
					pos    = (left_q == 3'd2) ? 2'd0 : 2'd1;
					acc_n  = acc_q | (32'(b) << {pos, 3'b000});
					left_n = left_q - 3'd1;
					if (left_n == 3'd0) begin
						bundle_n.vmask[SLOT_MAIN] = 1'b1;
						bundle_n.rec[SLOT_MAIN]   = make_rec(start_w[15:0], held_q,
							KIND_SW_TARGET, sx16(acc_n[15:0]));
						swleft_n = swleft_q - 8'd1;
						acc_n    = '0;
						if (swleft_n == 8'd0)
							phase_n = PH_OPCODE;
						else
							left_n = 3'd2;
					end
				end
				PH_NAME: begin
					bundle_n.vmask[SLOT_MAIN] = 1'b1;
					if (b == 8'd0) begin
						bundle_n.rec[SLOT_MAIN] = make_rec(start_w[15:0], held_q,
							KIND_NAME_END, '0);
						phase_n = PH_OPCODE;
					end else begin
						bundle_n.rec[SLOT_MAIN] = make_rec(start_w[15:0], held_q,
							KIND_NAME_CHAR, 32'(b));
					end
				end
				default: begin
					phase_n = PH_OPCODE;
					if (pzero_q) begin
						// a held zero resolves here: double zero stops, else it was a NOP
						pzero_n = 1'b0;
						bundle_n.vmask[SLOT_ZERO] = 1'b1;
						if (b == 8'd0) begin
							bundle_n.rec[SLOT_ZERO] = make_rec(start_w[15:0], OP_NOP,
								KIND_STOP, '0);
							halted_n = 1'b1;
						end else begin
							bundle_n.rec[SLOT_ZERO] = make_rec(start_w[15:0], OP_NOP,
								KIND_INSTR, '0);
							take = 1'b1;
						end
					end else begin
						take = 1'b1;
					end
				end
			endcase

			if (take) begin
				start_n = off_q;
				held_n  = b;
				acc_n   = '0;
				if (b == OP_NOP) begin
					if (last) begin
						bundle_n.vmask[SLOT_MAIN] = 1'b1;
						bundle_n.rec[SLOT_MAIN]   = make_rec(off_w[15:0], OP_NOP, KIND_INSTR, '0);
					end else begin
						pzero_n = 1'b1;
					end
				end else if (b == OP_END) begin
					bundle_n.vmask[SLOT_MAIN] = 1'b1;
					bundle_n.rec[SLOT_MAIN]   = make_rec(off_w[15:0], b, KIND_END, '0);
					halted_n = 1'b1;
				end else if (operand_len(b) != 3'd0) begin
					phase_n = PH_IMM;
					left_n  = operand_len(b);
				end else if (b == OP_SWITCH) begin
					phase_n = PH_SWCOUNT;
				end else if ((b == OP_PUSH_ADDR) || (b == OP_CALL_NAME)) begin
					phase_n = PH_NAME;
				end else begin
					bundle_n.vmask[SLOT_MAIN] = 1'b1;
					bundle_n.rec[SLOT_MAIN]   = make_rec(off_w[15:0], b,
						is_single(b) ? KIND_INSTR : KIND_UNKNOWN, '0);
				end
			end

			if (last && !halted_n && (phase_n != PH_OPCODE)) begin
				trunc_w = 32'(start_n);
				bundle_n.vmask[SLOT_TRUNC] = 1'b1;
				bundle_n.rec[SLOT_TRUNC]   = make_rec(trunc_w[15:0], held_n, KIND_TRUNC, '0);
			end
		end

		if (accept) begin
			if (last) begin
				// the final byte closes the section: start over from reset
				off_n    = '0;
				phase_n  = PH_OPCODE;
				held_n   = '0;
				start_n  = '0;
				acc_n    = '0;
				left_n   = '0;
				swleft_n = '0;
				ffw_n    = '0;
				pzero_n  = 1'b0;
				halted_n = 1'b0;
			end else begin
				off_n = off_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q    <= '0;
			start_q  <= '0;
			phase_q  <= PH_OPCODE;
			held_q   <= '0;
			acc_q    <= '0;
			left_q   <= '0;
			swleft_q <= '0;
			ffw_q    <= '0;
			pzero_q  <= 1'b0;
			halted_q <= 1'b0;
		end else begin
			off_q    <= off_n;
			start_q  <= start_n;
			phase_q  <= phase_n;
			held_q   <= held_n;
			acc_q    <= acc_n;
			left_q   <= left_n;
			swleft_q <= swleft_n;
			ffw_q    <= ffw_n;
			pzero_q  <= pzero_n;
			halted_q <= halted_n;
		end
	end

	assign push   = accept && (bundle_n.vmask != '0);
	assign bundle = bundle_n;

endmodule

/* rtl/sbsd_queue.sv */
module sbsd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  sbsd_pkg::bundle_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output sbsd_pkg::bundle_t head
);
	import sbsd_pkg::*;

	bundle_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

/* rtl/sbsd_back.sv */
module sbsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              empty,
	input  sbsd_pkg::bundle_t head,
	output logic              pop,
	sbsd_out_if.source        result
);
	import sbsd_pkg::*;

	logic [SLOTS-1:0] done_q;
	logic [SLOTS-1:0] remaining;
	logic [SLOTS-1:0] sel_mask;
	logic [1:0]       sel;
	logic             last;
	logic             load;
	logic             valid_q;
	rec_t             rec_q;
	logic             run_last_q;

	assign remaining = head.vmask & ~done_q;

	always_comb begin
		if (remaining[SLOT_ZERO])
			sel = 2'(SLOT_ZERO);
		else if (remaining[SLOT_MAIN])
			sel = 2'(SLOT_MAIN);
		else
			sel = 2'(SLOT_TRUNC);
		sel_mask = '0;
		sel_mask[sel] = 1'b1;
	end

	assign last = ((remaining & ~sel_mask) == '0);
	assign load = !empty && (!valid_q || result.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (result.ready)
				valid_q <= 1'b0;
			if (load) begin
				if (last)
					done_q <= '0;
				else
					done_q <= done_q | sel_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rec_q      <= head.rec[sel];
			run_last_q <= last;
		end
	end

	assign result.valid        = valid_q;
	assign result.instr_offset = rec_q.instr_offset;
	assign result.opcode       = rec_q.opcode;
	assign result.record_kind  = rec_q.kind;
	assign result.value_a      = $signed(rec_q.value_a);
	assign result.value_b      = $signed(rec_q.value_b);
	assign result.any_marker   = rec_q.any_marker;
	assign result.bad_variable = rec_q.bad_variable;
	assign result.run_last     = run_last_q;

endmodule

/* rtl/script_bytecode_stream_decoder.sv */
// Script bytecode decoder: takes one code byte per cycle on the code channel and
// emits decoded records on the result channel. The front end tracks the byte
// offset and the instruction being assembled, and turns each byte into a bundle
// of zero to three records (a resolved held zero, the main record, a truncation
// record). Bundles wait in a four-entry queue; the back end sends one record per
// cycle from an output register while the result channel is ready, with run_last
// on the last record of each byte. A byte is taken every cycle while the queue
// has room, so the sustained rate is one byte per cycle when bytes give at most
// one record each; a byte giving two records is sent as two in turn. The first
// record of a byte passes through the queue and then the output register. A byte
// with stream_last set closes the section; the next byte restarts at offset 0.
module script_bytecode_stream_decoder #(
	parameter int OFFSET_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	sbsd_in_if.sink    code,
	sbsd_out_if.source result
);
	import sbsd_pkg::*;

	logic    push;
	logic    full;
	logic    pop;
	logic    empty;
	bundle_t wr_bundle;
	bundle_t head;

	// front end: accept bytes, hold decode state, build record bundles
	sbsd_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code),
		.full   (full),
		.push   (push),
		.bundle (wr_bundle)
	);

	// decouple the byte rate from the record rate
	sbsd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	// back end: drain one record per request through the output register
	sbsd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

/* tb/sv/script_bytecode_stream_decoder_test.sv */
import sbsd_pkg::*;

typedef struct {
	logic [15:0] offset;
	logic [7:0]  op;
	rec_kind_t   kind;
	logic [31:0] val_a;
	logic [15:0] val_b;
	logic        any_m;
	logic        bad_var;
	logic        run_last;
} decoded_rec_t;

class decode_scoreboard;
	decoded_rec_t records_due[$];
	decoded_rec_t batch[$];
	int faults;

	logic [15:0] byte_pos;
	phase_t      phase;
	logic [7:0]  held_op;
	logic [15:0] start_pos;
	logic [31:0] acc;
	logic [2:0]  left;
	logic [2:0]  op_bytes;
	logic [7:0]  entries_left;
	logic [15:0] frame_lo;
	logic        zero_held;
	logic        stopped;

	function new();
		faults = 0;
		clear_state();
	endfunction

	function void clear_state();
		byte_pos     = '0;
		phase        = PH_OPCODE;
		held_op      = '0;
		start_pos    = '0;
		acc          = '0;
		left         = '0;
		op_bytes     = '0;
		entries_left = '0;
		frame_lo     = '0;
		zero_held    = 1'b0;
		stopped      = 1'b0;
	endfunction

	function void add_rec(logic [15:0] off, logic [7:0] op, rec_kind_t kind, logic [31:0] a,
			logic [15:0] vb = '0, logic any_m = 1'b0, logic bad = 1'b0);
		decoded_rec_t r;
		if (batch.size() >= SLOTS) return;
		r.offset   = off;
		r.op       = op;
		r.kind     = kind;
		r.val_a    = a;
		r.val_b    = vb;
		r.any_m    = any_m;
		r.bad_var  = bad;
		r.run_last = 1'b0;
		batch.insert(batch.size(), r);
	endfunction

	function void take_opcode(logic [7:0] b, logic [15:0] off, logic last);
		start_pos = off;
		held_op   = b;
		acc       = '0;
		left      = '0;
		case (b)
			OP_NOP: begin
				if (last) add_rec(off, b, KIND_INSTR, '0);
				else zero_held = 1'b1;
			end
			OP_END: begin
				add_rec(off, b, KIND_END, '0);
				stopped = 1'b1;
			end
			OP_PUSH_DWORD, OP_PUSH_RAW, OP_FRAME: begin
				phase = PH_IMM;
				left  = 3'd4;
			end
			OP_PUSH_WORD, OP_JUMP_20, OP_JUMP_21, OP_JUMP_23: begin
				phase = PH_IMM;
				left  = 3'd2;
			end
			OP_PUSH_BYTE, OP_LOAD_VAR, OP_STORE_VAR: begin
				phase = PH_IMM;
				left  = 3'd1;
			end
			OP_SWITCH: phase = PH_SWCOUNT;
			OP_PUSH_ADDR, OP_CALL_NAME: phase = PH_NAME;
			default: begin
				if (b == OP_SINGLE_04 || b == OP_SINGLE_22 ||
						(b >= OP_SINGLE_LO && b <= OP_SINGLE_HI))
					add_rec(off, b, KIND_INSTR, '0);
				else
					add_rec(off, b, KIND_UNKNOWN, '0);
			end
		endcase
		op_bytes = left;
	endfunction

	// predict the records of one accepted code byte
	function void note_request(logic [7:0] b, logic last);
		logic [15:0] off;
		logic [1:0]  idx;
		logic [31:0] a;
		logic [15:0] vb;
		logic        any_m;
		logic        bad;
		off = byte_pos;
		batch.delete();
		if (!stopped) begin
			case (phase)
				PH_IMM: begin
					idx = 2'(op_bytes - left);
					acc = acc | (32'(b) << (8 * idx));
					left = left - 3'd1;
					if (held_op == OP_FRAME && left == 3'd2) frame_lo = acc[15:0];
					if (left == 3'd0) begin
						phase = PH_OPCODE;
						a     = {{16{acc[15]}}, acc[15:0]};
						vb    = '0;
						any_m = 1'b0;
						bad   = 1'b0;
						case (held_op)
							OP_PUSH_DWORD: begin
								a     = acc;
								any_m = (acc == ANY_VALUE);
							end
							OP_PUSH_RAW: a = acc;
							OP_FRAME: begin
								a  = {{16{frame_lo[15]}}, frame_lo};
								vb = acc[31:16];
							end
							OP_PUSH_BYTE: a = {{24{acc[7]}}, acc[7:0]};
							OP_LOAD_VAR, OP_STORE_VAR: begin
								a   = {24'd0, acc[7:0]};
								bad = (acc[7:0] >= VAR_LIMIT);
							end
							default: ;
						endcase
						add_rec(start_pos, held_op, KIND_INSTR, a, vb, any_m, bad);
					end
				end
				PH_SWCOUNT: begin
					entries_left = b;
					add_rec(start_pos, held_op, KIND_SW_HEAD, {24'd0, b});
					if (b == 8'd0) begin
						phase = PH_OPCODE;
					end else begin
						phase = PH_SWENTRY;
						left  = 3'd2;
						acc   = '0;
					end
				end
				PH_SWENTRY: begin
					idx = 2'(3'd2 - left);
					acc = acc | (32'(b) << (8 * idx[0]));
					left = left - 3'd1;
					if (left == 3'd0) begin
						add_rec(start_pos, held_op, KIND_SW_TARGET,
							{{16{acc[15]}}, acc[15:0]});
						entries_left = entries_left - 8'd1;
						acc = '0;
						if (entries_left == 8'd0) phase = PH_OPCODE;
						else left = 3'd2;
					end
				end
				PH_NAME: begin
					if (b == 8'd0) begin
						add_rec(start_pos, held_op, KIND_NAME_END, '0);
						phase = PH_OPCODE;
					end else begin
						add_rec(start_pos, held_op, KIND_NAME_CHAR, {24'd0, b});
					end
				end
				default: begin
					phase = PH_OPCODE;
					if (zero_held) begin
						zero_held = 1'b0;
						if (b == OP_NOP) begin
							add_rec(start_pos, OP_NOP, KIND_STOP, '0);
							stopped = 1'b1;
						end else begin
							add_rec(start_pos, OP_NOP, KIND_INSTR, '0);
							take_opcode(b, off, last);
						end
					end else begin
						take_opcode(b, off, last);
					end
				end
			endcase
			if (last && !stopped && phase != PH_OPCODE)
				add_rec(start_pos, held_op, KIND_TRUNC, '0);
		end
		byte_pos = off + 16'd1;
		if (last) clear_state();
		if (batch.size() != 0) batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i]) records_due.insert(records_due.size(), batch[i]);
	endfunction

	function string show(decoded_rec_t r);
		return $sformatf("off=%h op=%h kind=%0d a=%h b=%h any=%b bad=%b last=%b",
			r.offset, r.op, r.kind, r.val_a, r.val_b, r.any_m, r.bad_var, r.run_last);
	endfunction

	function void report_fault(string msg);
		faults++;
		if (faults <= 10) $display("%s", msg);
	endfunction

	// compare one delivered record against the oldest prediction
	function void check_record(decoded_rec_t got);
		decoded_rec_t want;
		if (records_due.size() == 0) begin
			report_fault({"unexpected record: ", show(got)});
			return;
		end
		want = records_due.pop_front();
		if (got.offset !== want.offset || got.op !== want.op || got.kind !== want.kind ||
				got.val_a !== want.val_a || got.val_b !== want.val_b ||
				got.any_m !== want.any_m || got.bad_var !== want.bad_var ||
				got.run_last !== want.run_last)
			report_fault({"record mismatch: expected ", show(want), " got ", show(got)});
	endfunction
endclass

module script_bytecode_stream_decoder_test;

	// fixed opening stream; bit 8 marks the final byte of a code section
	localparam logic [8:0] STREAM_END = 9'h100;
	localparam logic [8:0] OPENING[34] = '{
		9'(OP_PUSH_DWORD), 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,  // push of the "any" marker
		9'(OP_FRAME), 9'h000, 9'h080, 9'h0FF, 9'h07F,       // frame words at both extremes
		9'(OP_LOAD_VAR), 9'h004,                            // first out-of-range variable
		9'(OP_SWITCH), 9'h000,                              // switch with no entries
		9'(OP_NOP), 9'(OP_SINGLE_HI),                       // zero then a real opcode
		9'(OP_CALL_NAME), 9'h041, 9'h000,                   // one-character name
		STREAM_END | 9'(OP_NOP),                            // zero as the final byte
		9'(OP_PUSH_WORD), STREAM_END | 9'h080,              // section ends inside an operand
		9'(OP_NOP), 9'(OP_NOP), 9'h033, STREAM_END | 9'h0FF, // stop, then ignored bytes
		9'(OP_PUSH_ADDR), STREAM_END | 9'h042,              // unterminated name
		9'(OP_END), STREAM_END | 9'(OP_SINGLE_04),          // END, then an ignored byte
		9'(OP_SWITCH), 9'h0FF, 9'h034, STREAM_END | 9'h092  // widest count, cut after an entry
	};
	localparam logic [7:0] WORD_OPS[4] = '{OP_PUSH_WORD, OP_JUMP_20, OP_JUMP_21, OP_JUMP_23};
	localparam logic [7:0] BYTE_OPS[3] = '{OP_PUSH_BYTE, OP_LOAD_VAR, OP_STORE_VAR};
	localparam logic [7:0] DWORD_OPS[3] = '{OP_PUSH_DWORD, OP_PUSH_RAW, OP_FRAME};

	logic clk;
	logic arst_n;
	logic steady = 1'b0;    // suppress idling on both channels
	int   bytes_sent = 0;
	logic [7:0] section_q[$];

	decode_scoreboard board;

	sbsd_in_if  code_ch();
	sbsd_out_if result_ch();

	script_bytecode_stream_decoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.code   (code_ch),
		.result (result_ch)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Drive one code byte as a request: idle at random first, then hold it until
	// the decoder takes it, and note it for prediction at the accepting edge.
	task automatic send_request(input logic [7:0] b, input logic last);
		while (!steady && $urandom_range(99) < 24) begin
			code_ch.valid <= 1'b0;
			@(negedge clk);
		end
		code_ch.valid       <= 1'b1;
		code_ch.code_byte   <= b;
		code_ch.stream_last <= last;
		@(posedge clk);
		while (!code_ch.ready) @(posedge clk);
		board.note_request(b, last);
		bytes_sent++;
		@(negedge clk);
	endtask

	// append one byte to the section being built
	function automatic void add_byte(input logic [7:0] v);
		section_q.insert(section_q.size(), v);
	endfunction

	// append n bytes of v, least significant first
	task automatic append_le(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
	endtask

	function automatic logic [7:0] pick_plain_op();
		case ($urandom_range(0, 3))
			0: return OP_SINGLE_04;
			1: return OP_SINGLE_22;
			2: return 8'($urandom_range(OP_SINGLE_LO, OP_SINGLE_HI));
			default: return 8'($urandom_range(OP_FRAME + 1, 8'hFF));
		endcase
	endfunction

	// Append one well-formed instruction with random operands.
	task automatic append_instr();
		logic [31:0] v;
		int cnt;
		case ($urandom_range(0, 11))
			0, 1: begin
				add_byte(DWORD_OPS[$urandom_range(0, 2)]);
				v = ($urandom_range(0, 3) == 0) ? ANY_VALUE : $urandom;
				append_le(v, 4);
			end
			2, 3: begin
				add_byte(WORD_OPS[$urandom_range(0, 3)]);
				append_le($urandom, 2);
			end
			4, 5: begin
				add_byte(BYTE_OPS[$urandom_range(0, 2)]);
				add_byte(8'($urandom_range(0, 1) ? $urandom_range(0, 7)
					: $urandom_range(0, 255)));
			end
			6: begin
				// keep most switches short; an occasional one runs longer
				cnt = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 12)
					: $urandom_range(0, 3);
				add_byte(OP_SWITCH);
				add_byte(8'(cnt));
				repeat (cnt) append_le($urandom, 2);
			end
			7: begin
				add_byte($urandom_range(0, 1) ? OP_PUSH_ADDR : OP_CALL_NAME);
				repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(1, 255)));
				add_byte(8'd0);
			end
			8: add_byte(OP_NOP);
			default: add_byte(pick_plain_op());
		endcase
	endtask

	// Build one code section and send it, cutting it short now and then so that
	// the final byte lands inside an instruction.
	task automatic run_section();
		int cut;
		section_q.delete();
		if ($urandom_range(0, 7) == 0) begin
			// noise: raw bytes with no structure
			repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
		end else begin
			repeat ($urandom_range(1, 6)) append_instr();
			case ($urandom_range(0, 9))
				0, 1, 2: add_byte(OP_END);
				3: begin
					add_byte(OP_NOP);
					add_byte(OP_NOP);
				end
				default: ;
			endcase
			// bytes after a halt must be swallowed
			repeat ($urandom_range(0, 1)) add_byte(8'($urandom));
		end
		cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, section_q.size() - 1)
			: section_q.size() - 1;
		for (int i = 0; i <= cut; i++) send_request(section_q[i], i == cut);
	endtask

	// Result channel: drop ready at random on each falling edge unless steady.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= steady || ($urandom_range(99) >= 24);
		end
	end

	// Check every record handed over at a rising edge.
	always @(posedge clk) begin
		decoded_rec_t seen;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen.offset   = result_ch.instr_offset;
			seen.op       = result_ch.opcode;
			seen.kind     = rec_kind_t'(result_ch.record_kind);
			seen.val_a    = result_ch.value_a;
			seen.val_b    = result_ch.value_b;
			seen.any_m    = result_ch.any_marker;
			seen.bad_var  = result_ch.bad_variable;
			seen.run_last = result_ch.run_last;
			board.check_record(seen);
		end
	end

	initial begin
		board = new();
		arst_n              = 1'b0;
		code_ch.valid       = 1'b0;
		code_ch.code_byte   = '0;
		code_ch.stream_last = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed opening: extremes and the special cases
		foreach (OPENING[i]) send_request(OPENING[i][7:0], OPENING[i][8]);

		// random sections with random idling on both sides
		while (bytes_sent < 90) run_section();

		// One section with no idling on either side, bytes back to back.
		steady = 1'b1;
		section_q.delete();
		repeat (24) add_byte(pick_plain_op());
		repeat (4) append_instr();
		foreach (section_q[i]) send_request(section_q[i], i == section_q.size() - 1);
		steady = 1'b0;

		// more random sections to round off the run
		while (bytes_sent < 150) run_section();

		code_ch.valid <= 1'b0;
		while (board.records_due.size() != 0) @(posedge clk);
		// drain: catch any stray record after the last expected one
		repeat (16) @(posedge clk);
		if (board.faults == 0)
			$display("script_bytecode_stream_decoder_test passed");
		else
			$display("script_bytecode_stream_decoder_test failed");
		$finish;
	end

	// Hard limit on the run length.
	initial begin
		#1600000;
		$display("script_bytecode_stream_decoder_test failed");
		$finish;
	end

endmodule

/* script_bytecode_stream_decoder.f */
rtl/sbsd_pkg.sv
rtl/sbsd_in_if.sv
rtl/sbsd_out_if.sv
rtl/sbsd_front.sv
rtl/sbsd_queue.sv
rtl/sbsd_back.sv
rtl/script_bytecode_stream_decoder.sv
tb/sv/script_bytecode_stream_decoder_test.sv
